// ===== sv/tpi_pkg.sv =====
// package: widths and payload types of the three-plane intersection block
`default_nettype none
package tpi_pkg;

    localparam int W_IN    = 32;
    localparam int W_PROD  = 2 * W_IN;
    localparam int W_CROSS = W_PROD + 1;
    localparam int W_TERM  = W_CROSS + W_IN;
    localparam int QBITS   = W_IN + 1;
    localparam int W_REM   = W_TERM + QBITS + 1;

    typedef struct packed {
        logic signed [W_IN-1:0] plane0_nx;
        logic signed [W_IN-1:0] plane0_ny;
        logic signed [W_IN-1:0] plane0_nz;
        logic signed [W_IN-1:0] plane0_off;
        logic signed [W_IN-1:0] plane1_nx;
        logic signed [W_IN-1:0] plane1_ny;
        logic signed [W_IN-1:0] plane1_nz;
        logic signed [W_IN-1:0] plane1_off;
        logic signed [W_IN-1:0] plane2_nx;
        logic signed [W_IN-1:0] plane2_ny;
        logic signed [W_IN-1:0] plane2_nz;
        logic signed [W_IN-1:0] plane2_off;
    } t_plane_req;

    typedef struct packed {
        logic signed [W_IN-1:0] point_x;
        logic signed [W_IN-1:0] point_y;
        logic signed [W_IN-1:0] point_z;
        logic                   degenerate;
        logic                   saturated;
    } t_point_rsp;

    typedef struct packed {
        logic [2:0][W_REM-1:0] num;
        logic [W_REM-1:0]      den;
        logic [2:0]            neg;
        logic                  deg;
    } t_div_req;

endpackage
`default_nettype wire

// ===== sv/tpi_if.sv =====
// interfaces: plane request channel and point result channel
`default_nettype none
interface tpi_req_if;
    import tpi_pkg::*;
    logic       valid;
    logic       ready;
    t_plane_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpi_rsp_if;
    import tpi_pkg::*;
    logic       valid;
    logic       ready;
    t_point_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/three_plane_intersection.sv =====
// top level: three-plane intersection point pipeline
// One request enters per cycle while the result side does not stall, and each
// passes through six multiply and sum stages, one overflow stage and 33 quotient stages
// of the three parallel divider lanes, and the output register. The whole
// pipeline advances together, so a stall on the result side holds every stage.
`default_nettype none
module three_plane_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpi_req_if.sink   i_in,
    tpi_rsp_if.source o_out
);
    import tpi_pkg::*;

    logic                   ce;
    logic                   f_valid;
    t_div_req               f_div;
    logic [2:0]             l_valid;
    logic signed [W_IN-1:0] l_coord [3];
    logic [2:0]             l_sat;
    logic [2:0]             l_deg;

    logic                   r_o_valid;
    t_point_rsp             r_o_data;
    t_point_rsp             n_o_data;

    assign ce         = !r_o_valid || o_out.ready;
    assign i_in.ready = ce;

    tpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_in.valid),
        .i_req   (i_in.data),
        .o_valid (f_valid),
        .o_div   (f_div)
    );

    for (genvar j = 0; j < 3; j++) begin : g_lane
        tpi_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (f_valid),
            .i_num   (f_div.num[j]),
            .i_den   (f_div.den),
            .i_neg   (f_div.neg[j]),
            .i_deg   (f_div.deg),
            .o_valid (l_valid[j]),
            .o_coord (l_coord[j]),
            .o_sat   (l_sat[j]),
            .o_deg   (l_deg[j])
        );
    end

    always_comb begin
        if (&l_deg) begin
            n_o_data.point_x    = '0;
            n_o_data.point_y    = '0;
            n_o_data.point_z    = '0;
            n_o_data.degenerate = 1'b1;
            n_o_data.saturated  = 1'b0;
        end else begin
            n_o_data.point_x    = l_coord[0];
            n_o_data.point_y    = l_coord[1];
            n_o_data.point_z    = l_coord[2];
            n_o_data.degenerate = 1'b0;
            n_o_data.saturated  = |l_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ce) begin
            r_o_valid <= &l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_data;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.degenerate |->
            o_out.data.point_x == '0 && o_out.data.point_y == '0 &&
            o_out.data.point_z == '0 && !o_out.data.saturated)
        else $error("degenerate result with nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("request taken while result stalled");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_valid == 3'b000 || l_valid == 3'b111) &&
        (l_deg == 3'b000 || l_deg == 3'b111 || !l_valid[0]))
        else $error("divider lanes out of step");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.saturated |->
            o_out.data.point_x == 32'h7fffffff || o_out.data.point_x == 32'h80000000 ||
            o_out.data.point_y == 32'h7fffffff || o_out.data.point_y == 32'h80000000 ||
            o_out.data.point_z == 32'h7fffffff || o_out.data.point_z == 32'h80000000)
        else $error("saturation flag without a clipped coordinate");

endmodule
`default_nettype wire

// ===== sv/tpi_front.sv =====
// front pipeline: cross products, determinant, numerators, magnitudes
`default_nettype none
module tpi_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ce,
    input  wire logic              i_valid,
    input  tpi_pkg::t_plane_req    i_req,
    output logic                   o_valid,
    output tpi_pkg::t_div_req      o_div
);
    import tpi_pkg::*;

    logic signed [W_IN-1:0] n  [3][3];
    logic signed [W_IN-1:0] d  [3];
    logic signed [W_IN-1:0] pa [3][3];
    logic signed [W_IN-1:0] pb [3][3];

    logic [6:1] r_v;

    logic signed [W_PROD-1:0]  r_m  [3][6];
    logic signed [W_IN-1:0]    r_d1 [3];
    logic signed [W_IN-1:0]    r_n1 [3];
    logic signed [W_CROSS-1:0] r_c  [3][3];
    logic signed [W_IN-1:0]    r_d2 [3];
    logic signed [W_IN-1:0]    r_n2 [3];
    logic signed [W_CROSS-1:0] r_lo [3][3];
    logic signed [W_CROSS-1:0] r_hi [3][3];
    logic signed [W_CROSS-1:0] r_dlo [3];
    logic signed [W_CROSS-1:0] r_dhi [3];
    logic signed [W_TERM-1:0]  r_t  [3][3];
    logic signed [W_TERM-1:0]  r_dt [3];
    logic signed [W_TERM-1:0]  r_num [3];
    logic signed [W_TERM-1:0]  r_det;
    t_div_req                  r_out;

    logic                      dneg;
    logic [W_TERM-1:0]         dmag;
    logic [W_TERM-1:0]         nmag [3];

    assign n[0][0] = i_req.plane0_nx;
    assign n[0][1] = i_req.plane0_ny;
    assign n[0][2] = i_req.plane0_nz;
    assign n[1][0] = i_req.plane1_nx;
    assign n[1][1] = i_req.plane1_ny;
    assign n[1][2] = i_req.plane1_nz;
    assign n[2][0] = i_req.plane2_nx;
    assign n[2][1] = i_req.plane2_ny;
    assign n[2][2] = i_req.plane2_nz;
    assign d[0]    = i_req.plane0_off;
    assign d[1]    = i_req.plane1_off;
    assign d[2]    = i_req.plane2_off;

    // pairs: n1 x n2, n2 x n0, n0 x n1
    assign pa[0] = n[1];
    assign pb[0] = n[2];
    assign pa[1] = n[2];
    assign pb[1] = n[0];
    assign pa[2] = n[0];
    assign pb[2] = n[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k][0] <= W_PROD'(pa[k][1]) * W_PROD'(pb[k][2]);
                r_m[k][1] <= W_PROD'(pa[k][2]) * W_PROD'(pb[k][1]);
                r_m[k][2] <= W_PROD'(pa[k][2]) * W_PROD'(pb[k][0]);
                r_m[k][3] <= W_PROD'(pa[k][0]) * W_PROD'(pb[k][2]);
                r_m[k][4] <= W_PROD'(pa[k][0]) * W_PROD'(pb[k][1]);
                r_m[k][5] <= W_PROD'(pa[k][1]) * W_PROD'(pb[k][0]);
                r_d1[k]   <= d[k];
                r_n1[k]   <= n[0][k];
            end
            for (int k = 0; k < 3; k++) begin
                r_c[k][0] <= W_CROSS'(r_m[k][0]) - W_CROSS'(r_m[k][1]);
                r_c[k][1] <= W_CROSS'(r_m[k][2]) - W_CROSS'(r_m[k][3]);
                r_c[k][2] <= W_CROSS'(r_m[k][4]) - W_CROSS'(r_m[k][5]);
                r_d2[k]   <= r_d1[k];
                r_n2[k]   <= r_n1[k];
            end
            // split each cross component into low 32 and high 33 bits
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_lo[k][j] <= W_CROSS'(r_d2[k]) *
                                  W_CROSS'($signed({1'b0, r_c[k][j][W_IN-1:0]}));
                    r_hi[k][j] <= W_CROSS'(r_d2[k]) *
                                  W_CROSS'($signed(r_c[k][j][W_CROSS-1:W_IN]));
                end
                r_dlo[k] <= W_CROSS'(r_n2[k]) *
                            W_CROSS'($signed({1'b0, r_c[0][k][W_IN-1:0]}));
                r_dhi[k] <= W_CROSS'(r_n2[k]) *
                            W_CROSS'($signed(r_c[0][k][W_CROSS-1:W_IN]));
            end
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_t[k][j] <= (W_TERM'(r_hi[k][j]) <<< W_IN) + W_TERM'(r_lo[k][j]);
                end
                r_dt[k] <= (W_TERM'(r_dhi[k]) <<< W_IN) + W_TERM'(r_dlo[k]);
            end
            for (int j = 0; j < 3; j++) begin
                r_num[j] <= r_t[0][j] + r_t[1][j] + r_t[2][j];
            end
            r_det <= r_dt[0] + r_dt[1] + r_dt[2];
            for (int j = 0; j < 3; j++) begin
                r_out.num[j] <= W_REM'(nmag[j]) << FRAC_BITS;
                r_out.neg[j] <= (r_num[j][W_TERM-1] == dneg);
            end
            r_out.den <= W_REM'(dmag);
            r_out.deg <= (r_det == '0);
        end
    end

    always_comb begin
        dneg = r_det[W_TERM-1];
        dmag = dneg ? W_TERM'(-r_det) : W_TERM'(r_det);
        for (int j = 0; j < 3; j++) begin
            nmag[j] = r_num[j][W_TERM-1] ? W_TERM'(-r_num[j]) : W_TERM'(r_num[j]);
        end
    end

    assign o_valid = r_v[6];
    assign o_div   = r_out;

endmodule
`default_nettype wire

// ===== sv/tpi_div.sv =====
// pipelined restoring divider lane with signed saturation
`default_nettype none
module tpi_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_ce,
    input  wire logic                       i_valid,
    input  wire logic [tpi_pkg::W_REM-1:0]  i_num,
    input  wire logic [tpi_pkg::W_REM-1:0]  i_den,
    input  wire logic                       i_neg,
    input  wire logic                       i_deg,
    output logic                            o_valid,
    output logic signed [tpi_pkg::W_IN-1:0] o_coord,
    output logic                            o_sat,
    output logic                            o_deg
);
    import tpi_pkg::*;

    logic [QBITS:0]     r_v;
    logic [W_REM-1:0]   r_rem [QBITS];
    logic [W_REM-1:0]   r_den [QBITS];
    logic [QBITS-1:0]   r_q   [QBITS+1];
    logic               r_ovf [QBITS+1];
    logic               r_neg [QBITS+1];
    logic               r_deg [QBITS+1];

    logic [QBITS-1:0]   q;
    logic [QBITS-1:0]   qneg;
    logic               sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[QBITS-1:0], i_valid};
        end
    end

    // input stage: register the operands and flag a quotient above 33 bits
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (i_num >= (i_den << QBITS));
            r_neg[0] <= i_neg;
            r_deg[0] <= i_deg;
        end
    end

    for (genvar s = 1; s <= QBITS; s++) begin : g_step
        localparam int BIT = QBITS - s;
        logic [W_REM-1:0] dsh;
        logic             ge;
        assign dsh = r_den[s-1] << BIT;
        assign ge  = (r_rem[s-1] >= dsh);
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[s]   <= r_q[s-1] | (QBITS'(ge) << BIT);
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
                r_deg[s] <= r_deg[s-1];
            end
        end
        if (s < QBITS) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[s] <= ge ? (r_rem[s-1] - dsh) : r_rem[s-1];
                    r_den[s] <= r_den[s-1];
                end
            end
        end
    end

    always_comb begin
        q    = r_q[QBITS];
        qneg = QBITS'(0) - q;
        if (r_neg[QBITS]) begin
            sat     = r_ovf[QBITS] || (q > {2'b01, {(W_IN-1){1'b0}}});
            o_coord = sat ? $signed({1'b1, {(W_IN-1){1'b0}}}) : $signed(qneg[W_IN-1:0]);
        end else begin
            sat     = r_ovf[QBITS] || (q[QBITS-1:W_IN-1] != '0);
            o_coord = sat ? $signed({1'b0, {(W_IN-1){1'b1}}}) : $signed(q[W_IN-1:0]);
        end
    end

    assign o_valid = r_v[QBITS];
    assign o_sat   = sat;
    assign o_deg   = r_deg[QBITS];

endmodule
`default_nettype wire
